@@ sv/pcog_pkg.sv @@
// Shared types, constants and helper functions for the occupancy gridder.
`timescale 1ns / 1ps

package pcog_pkg;

   // Grid geometry and coordinate precision
   localparam int MAX_COLS   = 256;
   localparam int MAX_ROWS   = 256;
   localparam int COORD_BITS = 32;

   // Fixed widths of the interface fields
   localparam int XY_BITS    = 32;
   localparam int CPM_BITS   = 16;
   localparam int DIM_BITS   = 9;
   localparam int CELL_BITS  = 8;
   localparam int OP_BITS    = 3;
   localparam int STAT_BITS  = 2;
   localparam int CSR_BITS   = 3;

   // Q16.16 times Q8.8 gives 24 fraction bits
   localparam int FRAC_SHIFT = 24;
   localparam int DIFF_BITS  = XY_BITS + 1;
   localparam int PROD_BITS  = XY_BITS + CPM_BITS;
   localparam int IDX_BITS   = PROD_BITS - FRAC_SHIFT;

   localparam int COL_BITS   = $clog2(MAX_COLS);
   localparam int ROW_BITS   = $clog2(MAX_ROWS);
   localparam int ADDR_BITS  = $clog2(MAX_ROWS * MAX_COLS);
   localparam int WRAP_BITS  = (COORD_BITS < XY_BITS) ? COORD_BITS : XY_BITS;

   localparam logic [COORD_BITS-1:0] BOX_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic [COORD_BITS-1:0] BOX_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   localparam logic [CELL_BITS-1:0] CELL_OCCUPIED   = 8'd0;
   localparam logic [CELL_BITS-1:0] CELL_FREE_PROB  = 8'd254;
   localparam logic [CELL_BITS-1:0] CELL_FREE_IMAGE = 8'd1;

   // Configuration register reset values
   localparam logic [XY_BITS-1:0]  RST_ORIGIN = '0;
   localparam logic [XY_BITS-1:0]  RST_Z_LOW  = -32'sd72090;
   localparam logic [XY_BITS-1:0]  RST_Z_HIGH = 32'sd6554;
   localparam logic [CPM_BITS-1:0] RST_CPM    = 16'd5120;
   localparam logic [DIM_BITS-1:0] RST_DIM    = 9'd256;

   typedef enum logic [OP_BITS-1:0] {
      OP_MEASURE   = 3'd0,
      OP_PLOT      = 3'd1,
      OP_READ      = 3'd2,
      OP_CLEAR     = 3'd3,
      OP_RESET_BOX = 3'd4
   } op_type;

   typedef enum logic [STAT_BITS-1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_MARKED  = 2'd1,
      STATUS_BAND    = 2'd2,
      STATUS_OUTSIDE = 2'd3
   } status_type;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_Z_LOW      = 3'd2,
      CSR_Z_HIGH     = 3'd3,
      CSR_CPM        = 3'd4,
      CSR_GRID_COLS  = 3'd5,
      CSR_GRID_ROWS  = 3'd6,
      CSR_MAP_FORMAT = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OFFSET,
      ST_SCALE,
      ST_ACCESS,
      ST_FINISH
   } state_type;

   // Stage strobes from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic offset;
      logic scale;
      logic access;
      logic load_rsp;
   } cmd_type;

   // Wrap a port coordinate to the coordinate precision
   function automatic logic [XY_BITS-1:0] wrap_coord(input logic [XY_BITS-1:0] v);
      logic [XY_BITS-1:0] r;
      for (int i = 0; i < XY_BITS; i++) begin
         r[i] = (i < WRAP_BITS) ? v[i] : v[WRAP_BITS-1];
      end
      return r;
   endfunction

   // Sign-extend or trim a coordinate to the box register width
   function automatic logic [COORD_BITS-1:0] to_box(input logic [XY_BITS-1:0] v);
      logic [COORD_BITS-1:0] r;
      for (int i = 0; i < COORD_BITS; i++) begin
         r[i] = (i < XY_BITS) ? v[i] : v[XY_BITS-1];
      end
      return r;
   endfunction

   // Box register back to port width
   function automatic logic [XY_BITS-1:0] box_to_port(input logic [COORD_BITS-1:0] b);
      logic [XY_BITS-1:0] r;
      for (int i = 0; i < XY_BITS; i++) begin
         r[i] = (i < COORD_BITS) ? b[i] : b[COORD_BITS-1];
      end
      return r;
   endfunction

endpackage

@@ sv/pcog_ctrl.sv @@
// Controller: walks one item through offset, scale, grid access and result load.
`timescale 1ns / 1ps

module pcog_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pcog_pkg::cmd_type cmd
);

   pcog_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != pcog_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcog_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         pcog_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = pcog_pkg::ST_OFFSET;
            end
         end
         pcog_pkg::ST_OFFSET: begin
            cmd.offset = 1'b1;
            state_in   = pcog_pkg::ST_SCALE;
         end
         pcog_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = pcog_pkg::ST_ACCESS;
         end
         pcog_pkg::ST_ACCESS: begin
            cmd.access = 1'b1;
            state_in   = pcog_pkg::ST_FINISH;
         end
         pcog_pkg::ST_FINISH: begin
            // hold the finished beat until the result register frees up
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = pcog_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pcog_pkg::ST_IDLE;
         end
      endcase
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over an untaken beat");

   a_accept_to_finish: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> ##4 (state_ff == pcog_pkg::ST_FINISH))
      else $error("accepted beat did not reach the finish stage on time");

endmodule

@@ sv/pcog_datapath.sv @@
// Datapath: configuration registers, offset and scale stages, bounding box and grid memory.
`timescale 1ns / 1ps

module pcog_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pcog_pkg::cmd_type                      cmd,
   input  logic                                   csr_valid,
   input  logic [pcog_pkg::CSR_BITS-1:0]          csr_index,
   input  logic [pcog_pkg::XY_BITS-1:0]           csr_wdata,
   input  logic [pcog_pkg::OP_BITS-1:0]           req_opcode,
   input  logic signed [pcog_pkg::XY_BITS-1:0]    req_point_x,
   input  logic signed [pcog_pkg::XY_BITS-1:0]    req_point_y,
   input  logic signed [pcog_pkg::XY_BITS-1:0]    req_point_z,
   input  logic [pcog_pkg::CELL_BITS-1:0]         req_cell_col_in,
   input  logic [pcog_pkg::CELL_BITS-1:0]         req_cell_row_in,
   output logic [pcog_pkg::STAT_BITS-1:0]         rsp_status,
   output logic [pcog_pkg::CELL_BITS-1:0]         rsp_cell_col,
   output logic [pcog_pkg::CELL_BITS-1:0]         rsp_cell_row,
   output logic [pcog_pkg::CELL_BITS-1:0]         rsp_cell_value,
   output logic signed [pcog_pkg::XY_BITS-1:0]    rsp_box_min_x,
   output logic signed [pcog_pkg::XY_BITS-1:0]    rsp_box_max_x,
   output logic signed [pcog_pkg::XY_BITS-1:0]    rsp_box_min_y,
   output logic signed [pcog_pkg::XY_BITS-1:0]    rsp_box_max_y
);

   // Configuration
   logic signed [pcog_pkg::XY_BITS-1:0]  origin_x_ff, origin_y_ff, z_low_ff, z_high_ff;
   logic [pcog_pkg::CPM_BITS-1:0]        cpm_ff;
   logic [pcog_pkg::DIM_BITS-1:0]        grid_cols_ff, grid_rows_ff;
   logic                                 map_format_ff;

   // Captured beat
   logic [pcog_pkg::OP_BITS-1:0]         op_ff;
   logic signed [pcog_pkg::XY_BITS-1:0]  px_ff, py_ff, pz_ff;
   logic [pcog_pkg::CELL_BITS-1:0]       cin_ff, rin_ff;

   // Offset stage
   logic signed [pcog_pkg::DIFF_BITS-1:0] dx_ff, dy_ff;
   logic                                  band_ok_ff;

   // Scale stage
   logic [pcog_pkg::PROD_BITS-1:0]       prod_x, prod_y;
   logic [pcog_pkg::IDX_BITS-1:0]        col_idx_ff, row_idx_ff, col_idx_in, row_idx_in;
   logic                                 neg_ff, neg_in;

   // Access stage
   logic                                 in_grid;
   logic [pcog_pkg::ADDR_BITS-1:0]       addr;
   logic                                 mem_we, mem_re;
   logic [pcog_pkg::CELL_BITS-1:0]       mem_wdata, mem_rdata_ff;
   logic [pcog_pkg::CELL_BITS-1:0]       free_value;
   logic [pcog_pkg::STAT_BITS-1:0]       status_ff, status_in;
   logic [pcog_pkg::CELL_BITS-1:0]       col_ff, col_in, row_ff, row_in, val_ff, val_in;
   logic                                 from_mem_ff, from_mem_in;

   // Bounding box
   logic signed [pcog_pkg::COORD_BITS-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic signed [pcog_pkg::COORD_BITS-1:0] min_x_in, max_x_in, min_y_in, max_y_in;
   logic signed [pcog_pkg::COORD_BITS-1:0] bx, by;

   logic [pcog_pkg::CELL_BITS-1:0] grid_mem [pcog_pkg::MAX_ROWS * pcog_pkg::MAX_COLS];

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= pcog_pkg::RST_ORIGIN;
         origin_y_ff   <= pcog_pkg::RST_ORIGIN;
         z_low_ff      <= pcog_pkg::RST_Z_LOW;
         z_high_ff     <= pcog_pkg::RST_Z_HIGH;
         cpm_ff        <= pcog_pkg::RST_CPM;
         grid_cols_ff  <= pcog_pkg::RST_DIM;
         grid_rows_ff  <= pcog_pkg::RST_DIM;
         map_format_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            pcog_pkg::CSR_ORIGIN_X:   origin_x_ff   <= pcog_pkg::wrap_coord(csr_wdata);
            pcog_pkg::CSR_ORIGIN_Y:   origin_y_ff   <= pcog_pkg::wrap_coord(csr_wdata);
            pcog_pkg::CSR_Z_LOW:      z_low_ff      <= pcog_pkg::wrap_coord(csr_wdata);
            pcog_pkg::CSR_Z_HIGH:     z_high_ff     <= pcog_pkg::wrap_coord(csr_wdata);
            pcog_pkg::CSR_CPM:        cpm_ff        <= csr_wdata[pcog_pkg::CPM_BITS-1:0];
            pcog_pkg::CSR_GRID_COLS:  grid_cols_ff  <= csr_wdata[pcog_pkg::DIM_BITS-1:0];
            pcog_pkg::CSR_GRID_ROWS:  grid_rows_ff  <= csr_wdata[pcog_pkg::DIM_BITS-1:0];
            pcog_pkg::CSR_MAP_FORMAT: map_format_ff <= csr_wdata[0];
            default:                  map_format_ff <= map_format_ff;
         endcase
      end
   end

   // Capture the accepted beat
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_opcode;
         px_ff  <= pcog_pkg::wrap_coord(req_point_x);
         py_ff  <= pcog_pkg::wrap_coord(req_point_y);
         pz_ff  <= pcog_pkg::wrap_coord(req_point_z);
         cin_ff <= req_cell_col_in;
         rin_ff <= req_cell_row_in;
      end
   end

   // Offsets from the grid origin and height band check
   always_ff @(posedge clock) begin
      if (cmd.offset) begin
         dx_ff <= {px_ff[pcog_pkg::XY_BITS-1], px_ff}
                - {origin_x_ff[pcog_pkg::XY_BITS-1], origin_x_ff};
         if (map_format_ff) begin
            dy_ff <= {origin_y_ff[pcog_pkg::XY_BITS-1], origin_y_ff}
                   - {py_ff[pcog_pkg::XY_BITS-1], py_ff};
         end else begin
            dy_ff <= {py_ff[pcog_pkg::XY_BITS-1], py_ff}
                   - {origin_y_ff[pcog_pkg::XY_BITS-1], origin_y_ff};
         end
         band_ok_ff <= (pz_ff >= z_low_ff) && (pz_ff <= z_high_ff);
      end
   end

   // Scale offsets to cell indices; floor of the product with 24 fraction bits
   assign prod_x = pcog_pkg::PROD_BITS'(dx_ff[pcog_pkg::XY_BITS-1:0])
                 * pcog_pkg::PROD_BITS'(cpm_ff);
   assign prod_y = pcog_pkg::PROD_BITS'(dy_ff[pcog_pkg::XY_BITS-1:0])
                 * pcog_pkg::PROD_BITS'(cpm_ff);

   always_comb begin
      if (op_ff == pcog_pkg::OP_PLOT) begin
         col_idx_in = prod_x[pcog_pkg::PROD_BITS-1:pcog_pkg::FRAC_SHIFT];
         row_idx_in = prod_y[pcog_pkg::PROD_BITS-1:pcog_pkg::FRAC_SHIFT];
         neg_in     = dx_ff[pcog_pkg::DIFF_BITS-1] || dy_ff[pcog_pkg::DIFF_BITS-1];
      end else begin
         col_idx_in = pcog_pkg::IDX_BITS'(cin_ff);
         row_idx_in = pcog_pkg::IDX_BITS'(rin_ff);
         neg_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         col_idx_ff <= col_idx_in;
         row_idx_ff <= row_idx_in;
         neg_ff     <= neg_in;
      end
   end

   // Grid access and box update
   assign in_grid = (col_idx_ff < pcog_pkg::IDX_BITS'(grid_cols_ff))
                 && (col_idx_ff < pcog_pkg::IDX_BITS'(pcog_pkg::MAX_COLS))
                 && (row_idx_ff < pcog_pkg::IDX_BITS'(grid_rows_ff))
                 && (row_idx_ff < pcog_pkg::IDX_BITS'(pcog_pkg::MAX_ROWS));

   assign addr = pcog_pkg::ADDR_BITS'(row_idx_ff[pcog_pkg::ROW_BITS-1:0])
               * pcog_pkg::ADDR_BITS'(pcog_pkg::MAX_COLS)
               + pcog_pkg::ADDR_BITS'(col_idx_ff[pcog_pkg::COL_BITS-1:0]);

   assign free_value = map_format_ff ? pcog_pkg::CELL_FREE_IMAGE : pcog_pkg::CELL_FREE_PROB;

   assign bx = pcog_pkg::to_box(px_ff);
   assign by = pcog_pkg::to_box(py_ff);

   always_comb begin
      status_in   = pcog_pkg::STATUS_DONE;
      col_in      = '0;
      row_in      = '0;
      val_in      = '0;
      from_mem_in = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_wdata   = pcog_pkg::CELL_OCCUPIED;
      min_x_in    = min_x_ff;
      max_x_in    = max_x_ff;
      min_y_in    = min_y_ff;
      max_y_in    = max_y_ff;
      case (op_ff)
         pcog_pkg::OP_MEASURE: begin
            if (bx < min_x_ff) min_x_in = bx;
            if (bx > max_x_ff) max_x_in = bx;
            if (by < min_y_ff) min_y_in = by;
            if (by > max_y_ff) max_y_in = by;
         end
         pcog_pkg::OP_PLOT: begin
            if (!band_ok_ff) begin
               status_in = pcog_pkg::STATUS_BAND;
            end else if (neg_ff || !in_grid) begin
               status_in = pcog_pkg::STATUS_OUTSIDE;
            end else begin
               status_in = pcog_pkg::STATUS_MARKED;
               mem_we    = cmd.access;
               col_in    = col_idx_ff[pcog_pkg::CELL_BITS-1:0];
               row_in    = row_idx_ff[pcog_pkg::CELL_BITS-1:0];
               val_in    = pcog_pkg::CELL_OCCUPIED;
            end
         end
         pcog_pkg::OP_READ, pcog_pkg::OP_CLEAR: begin
            if (!in_grid) begin
               status_in = pcog_pkg::STATUS_OUTSIDE;
            end else begin
               col_in = col_idx_ff[pcog_pkg::CELL_BITS-1:0];
               row_in = row_idx_ff[pcog_pkg::CELL_BITS-1:0];
               if (op_ff == pcog_pkg::OP_CLEAR) begin
                  mem_we    = cmd.access;
                  mem_wdata = free_value;
                  val_in    = free_value;
               end else begin
                  mem_re      = cmd.access;
                  from_mem_in = 1'b1;
               end
            end
         end
         pcog_pkg::OP_RESET_BOX: begin
            min_x_in = pcog_pkg::BOX_MAX;
            max_x_in = pcog_pkg::BOX_MIN;
            min_y_in = pcog_pkg::BOX_MAX;
            max_y_in = pcog_pkg::BOX_MIN;
         end
         default: begin
            status_in = pcog_pkg::STATUS_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.access) begin
         status_ff   <= status_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         val_ff      <= val_in;
         from_mem_ff <= from_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= pcog_pkg::BOX_MAX;
         max_x_ff <= pcog_pkg::BOX_MIN;
         min_y_ff <= pcog_pkg::BOX_MAX;
         max_y_ff <= pcog_pkg::BOX_MIN;
      end else if (cmd.access) begin
         min_x_ff <= min_x_in;
         max_x_ff <= max_x_in;
         min_y_ff <= min_y_in;
         max_y_ff <= max_y_in;
      end
   end

   // Grid memory: one port, write or registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[addr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         mem_rdata_ff <= grid_mem[addr];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status     <= status_ff;
         rsp_cell_col   <= col_ff;
         rsp_cell_row   <= row_ff;
         rsp_cell_value <= from_mem_ff ? mem_rdata_ff : val_ff;
         rsp_box_min_x  <= pcog_pkg::box_to_port(min_x_ff);
         rsp_box_max_x  <= pcog_pkg::box_to_port(max_x_ff);
         rsp_box_min_y  <= pcog_pkg::box_to_port(min_y_ff);
         rsp_box_max_y  <= pcog_pkg::box_to_port(max_y_ff);
      end
   end

   a_marked_is_occupied: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rsp && status_ff == pcog_pkg::STATUS_MARKED)
      |=> (rsp_cell_value == pcog_pkg::CELL_OCCUPIED))
      else $error("marked cell reported with a nonzero value");

   a_box_reset: assert property (@(posedge clock) disable iff (reset)
      (cmd.access && op_ff == pcog_pkg::OP_RESET_BOX)
      |=> (min_x_ff == pcog_pkg::BOX_MAX && max_y_ff == pcog_pkg::BOX_MIN))
      else $error("box not restored by a reset-box beat");

endmodule

@@ sv/point_cloud_occupancy_gridder_core.sv @@
// Top level of the point cloud occupancy gridder: controller plus datapath.
`timescale 1ns / 1ps

// Each beat passes from acceptance to the result register through capture, origin
// offset and height check, scaling by cells per metre (one 32x16 multiply per axis),
// one access to the single-port 256x256 grid memory, then the result load. A new beat
// is taken once the previous one has left those stages, so beats do not overlap, and
// the result load waits while the output side stalls; a result waiting in the output
// register does not hold off the next beat. The grid is not cleared by reset: software must clear
// every cell in use with clear beats before plotting or reading. Configuration writes
// are always ready and take effect on the next cycle.
module point_cloud_occupancy_gridder_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pcog_pkg::OP_BITS-1:0]        req_opcode,
   input  logic signed [pcog_pkg::XY_BITS-1:0] req_point_x,
   input  logic signed [pcog_pkg::XY_BITS-1:0] req_point_y,
   input  logic signed [pcog_pkg::XY_BITS-1:0] req_point_z,
   input  logic [pcog_pkg::CELL_BITS-1:0]      req_cell_col_in,
   input  logic [pcog_pkg::CELL_BITS-1:0]      req_cell_row_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pcog_pkg::STAT_BITS-1:0]      rsp_status,
   output logic [pcog_pkg::CELL_BITS-1:0]      rsp_cell_col,
   output logic [pcog_pkg::CELL_BITS-1:0]      rsp_cell_row,
   output logic [pcog_pkg::CELL_BITS-1:0]      rsp_cell_value,
   output logic signed [pcog_pkg::XY_BITS-1:0] rsp_box_min_x,
   output logic signed [pcog_pkg::XY_BITS-1:0] rsp_box_max_x,
   output logic signed [pcog_pkg::XY_BITS-1:0] rsp_box_min_y,
   output logic signed [pcog_pkg::XY_BITS-1:0] rsp_box_max_y,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pcog_pkg::CSR_BITS-1:0]       csr_index,
   input  logic [pcog_pkg::XY_BITS-1:0]        csr_wdata
);

   pcog_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   pcog_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   pcog_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_opcode      (req_opcode),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .req_cell_col_in (req_cell_col_in),
      .req_cell_row_in (req_cell_row_in),
      .rsp_status      (rsp_status),
      .rsp_cell_col    (rsp_cell_col),
      .rsp_cell_row    (rsp_cell_row),
      .rsp_cell_value  (rsp_cell_value),
      .rsp_box_min_x   (rsp_box_min_x),
      .rsp_box_max_x   (rsp_box_max_x),
      .rsp_box_min_y   (rsp_box_min_y),
      .rsp_box_max_y   (rsp_box_max_y)
   );

endmodule
